// ===== sv/nct_pkg.sv =====
// ----------------------------------------------------------------------------
// nct_pkg: shared types, widths and helpers for the narrow-phase pair test
// Fixed-point formats, the pair selector codes and the sideband that runs
// alongside the square-root and divider pipelines.
// ----------------------------------------------------------------------------
package nct_pkg;

    localparam int COORD_BITS  = 20;
    localparam int VEC_BITS    = 3 * COORD_BITS;
    localparam int NORM_FRAC   = 18;
    localparam int XP_BITS     = 8;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int SQ_BITS     = 2 * DIFF_BITS;
    localparam int RAD_BITS    = SQ_BITS + 2 * XP_BITS;
    localparam int ROOT_BITS   = RAD_BITS / 2;
    localparam int QUO_BITS    = NORM_FRAC + 1;
    localparam int DIVND_BITS  = COORD_BITS + NORM_FRAC + XP_BITS + 1;
    localparam int SQRT_STAGES = ROOT_BITS;
    localparam int DIV_STAGES  = QUO_BITS + 1;
    localparam int SAT_IN_BITS = 48;

    localparam logic signed [SAT_IN_BITS-1:0] SAT_HI =
        (48'sd1 <<< (COORD_BITS - 1)) - 48'sd1;
    localparam logic signed [SAT_IN_BITS-1:0] SAT_LO = -SAT_HI - 48'sd1;

    typedef enum logic [1:0] {
        FUNC_SPH_SPH   = 2'd0,
        FUNC_SPH_PLANE = 2'd1,
        FUNC_BOX_BOX   = 2'd2,
        FUNC_SPH_BOX   = 2'd3
    } func_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [VEC_BITS-1:0]          vec_t;

    // per-item results known early, plus what the back end still needs
    typedef struct packed {
        func_t                       func;
        logic                        early_hit;
        vec_t                        pos;
        vec_t                        norm;
        coord_t                      dep;
        vec_t                        ap;
        coord_t                      ra;
        logic signed [DIFF_BITS-1:0] rsum;
    } side_t;

    // signs of the centre difference and the coincident-centre flag
    typedef struct packed {
        logic [2:0] sgn;
        logic       zero;
    } dir_t;

    function automatic coord_t sat_coord(input logic signed [SAT_IN_BITS-1:0] v);
        if (v > SAT_HI) begin
            return coord_t'(SAT_HI);
        end else if (v < SAT_LO) begin
            return coord_t'(SAT_LO);
        end
        return coord_t'(v);
    endfunction

    function automatic coord_t coord_of(input vec_t v, input int idx);
        return coord_t'(v[idx*COORD_BITS +: COORD_BITS]);
    endfunction

    function automatic vec_t pack3(input coord_t x, input coord_t y, input coord_t z);
        return {z, y, x};
    endfunction

endpackage

// ===== sv/nct_front.sv =====
// ----------------------------------------------------------------------------
// nct_front: input stage and per-pair arithmetic
// Centre difference, squared lengths, box overlap, sphere-box distance and the
// complete sphere-plane result, over six register stages.
// ----------------------------------------------------------------------------
module nct_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [1:0]                            func,
    input  nct_pkg::vec_t                         a_pos,
    input  nct_pkg::vec_t                         a_size,
    input  nct_pkg::vec_t                         b_pos,
    input  nct_pkg::vec_t                         b_size,
    output logic                                  out_valid,
    output nct_pkg::side_t                        side,
    output logic [nct_pkg::SQ_BITS-1:0]           sqlen,
    output logic [2:0][nct_pkg::COORD_BITS-1:0]   mag,
    output nct_pkg::dir_t                         dir
);
    import nct_pkg::*;

    localparam logic signed [SQ_BITS:0]     RND_ACC  = (SQ_BITS+1)'(1) <<< (NORM_FRAC - 1);
    localparam logic signed [44:0]          RND_PROD = 45'sd1 <<< (NORM_FRAC - 1);

    // stage A: input capture
    logic   va_reg;
    func_t  func_a_reg;
    vec_t   ap_a_reg, as_a_reg, bp_a_reg, bs_a_reg;

    // stage B
    logic                                vb_reg, box_b_reg, box_b_next;
    func_t                               func_b_reg;
    vec_t                                ap_b_reg, bs_b_reg;
    coord_t                              ra_b_reg, rb_b_reg;
    logic signed [DIFF_BITS-1:0]         d_b_reg [3], d_b_next [3];
    logic signed [DIFF_BITS:0]           e_b_reg [3], e_b_next [3];

    // stage C
    logic                                vc_reg, box_c_reg;
    func_t                               func_c_reg;
    vec_t                                ap_c_reg, bs_c_reg;
    coord_t                              ra_c_reg;
    logic signed [DIFF_BITS-1:0]         rsum_c_reg, d_c_reg [3];
    logic [SQ_BITS-1:0]                  dsq_c_reg [3], dsq_c_next [3];
    logic [SQ_BITS+1:0]                  esq_c_reg [3], esq_c_next [3];
    logic signed [2*COORD_BITS:0]        pp_c_reg [3], pp_c_next [3];
    logic [2*COORD_BITS-1:0]             rr_c_reg, rr_c_next;

    // stage D
    logic                                vd_reg, box_d_reg, sb_d_reg, sb_d_next;
    func_t                               func_d_reg;
    vec_t                                ap_d_reg, bs_d_reg;
    coord_t                              ra_d_reg;
    logic signed [DIFF_BITS-1:0]         rsum_d_reg;
    logic [SQ_BITS-1:0]                  s_d_reg, s_d_next;
    logic signed [24:0]                  dist_d_reg, dist_d_next;
    logic [2:0][COORD_BITS-1:0]          mag_d_reg, mag_d_next;
    logic [2:0]                          sgn_d_reg, sgn_d_next;

    // stage E
    logic                                ve_reg, box_e_reg, sb_e_reg, pl_e_reg, pl_e_next;
    func_t                               func_e_reg;
    vec_t                                ap_e_reg, bs_e_reg;
    coord_t                              ra_e_reg, dep_e_reg, dep_e_next;
    logic signed [DIFF_BITS-1:0]         rsum_e_reg;
    logic [SQ_BITS-1:0]                  s_e_reg;
    logic signed [44:0]                  prod_e_reg [3], prod_e_next [3];
    logic [2:0][COORD_BITS-1:0]          mag_e_reg;
    logic [2:0]                          sgn_e_reg;

    // stage F: module output
    logic                                vf_reg;
    side_t                               side_f_reg, side_f_next;
    logic [SQ_BITS-1:0]                  s_f_reg;
    logic [2:0][COORD_BITS-1:0]          mag_f_reg;
    dir_t                                dir_f_reg, dir_f_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
            vf_reg <= ve_reg;
        end
    end

    // stage B: differences, box overlap, distance from the box on each axis
    always_comb begin
        coord_t                      ap, bp, as_i, bs_i;
        logic signed [DIFF_BITS-1:0] lo, hi, ext;
        logic [DIFF_BITS-1:0]        g;
        box_b_next = 1'b1;
        for (int i = 0; i < 3; i++) begin
            ap   = coord_of(ap_a_reg, i);
            bp   = coord_of(bp_a_reg, i);
            as_i = coord_of(as_a_reg, i);
            bs_i = coord_of(bs_a_reg, i);
            d_b_next[i] = DIFF_BITS'(ap) - DIFF_BITS'(bp);
            g   = d_b_next[i][DIFF_BITS-1] ? DIFF_BITS'(-d_b_next[i]) : d_b_next[i];
            ext = DIFF_BITS'(as_i) + DIFF_BITS'(bs_i);
            if ($signed({1'b0, g}) > (DIFF_BITS+1)'(ext)) begin
                box_b_next = 1'b0;
            end
            lo = DIFF_BITS'(bp) - DIFF_BITS'(bs_i);
            hi = DIFF_BITS'(bp) + DIFF_BITS'(bs_i);
            e_b_next[i] = '0;
            if ((DIFF_BITS+1)'(ap) < (DIFF_BITS+1)'(lo)) begin
                e_b_next[i] = (DIFF_BITS+1)'(lo) - (DIFF_BITS+1)'(ap);
            end
            if ((DIFF_BITS+1)'(ap) > (DIFF_BITS+1)'(hi)) begin
                e_b_next[i] = (DIFF_BITS+1)'(ap) - (DIFF_BITS+1)'(hi);
            end
        end
    end

    // stage C: products
    always_comb begin
        logic signed [SQ_BITS-1:0]   dp;
        logic signed [SQ_BITS+1:0]   ep;
        logic signed [2*COORD_BITS-1:0] rp;
        for (int i = 0; i < 3; i++) begin
            dp            = SQ_BITS'(d_b_reg[i]) * SQ_BITS'(d_b_reg[i]);
            dsq_c_next[i] = dp;
            ep            = (SQ_BITS+2)'(e_b_reg[i]) * (SQ_BITS+2)'(e_b_reg[i]);
            esq_c_next[i] = ep;
            pp_c_next[i]  = (2*COORD_BITS+1)'(d_b_reg[i])
                          * (2*COORD_BITS+1)'(coord_of(bs_b_reg, i));
        end
        rp        = (2*COORD_BITS)'(ra_b_reg) * (2*COORD_BITS)'(ra_b_reg);
        rr_c_next = rp;
    end

    // stage D: sums, sphere-box test, plane distance, direction split
    always_comb begin
        logic [SQ_BITS+3:0]          sq;
        logic signed [SQ_BITS:0]     acc;
        logic [DIFF_BITS-1:0]        dabs;
        s_d_next = dsq_c_reg[0] + dsq_c_reg[1] + dsq_c_reg[2];
        sq = (SQ_BITS+4)'(esq_c_reg[0]) + (SQ_BITS+4)'(esq_c_reg[1])
           + (SQ_BITS+4)'(esq_c_reg[2]);
        sb_d_next = sq <= (SQ_BITS+4)'(rr_c_reg);
        acc = (SQ_BITS+1)'(pp_c_reg[0]) + (SQ_BITS+1)'(pp_c_reg[1])
            + (SQ_BITS+1)'(pp_c_reg[2]) + RND_ACC;
        dist_d_next = $signed(acc[SQ_BITS:NORM_FRAC]);
        for (int i = 0; i < 3; i++) begin
            dabs          = d_c_reg[i][DIFF_BITS-1] ? DIFF_BITS'(-d_c_reg[i]) : d_c_reg[i];
            mag_d_next[i] = dabs[COORD_BITS-1:0];
            sgn_d_next[i] = d_c_reg[i][DIFF_BITS-1];
        end
    end

    // stage E: plane hit, depth and normal scaling
    always_comb begin
        logic signed [25:0] dp;
        pl_e_next  = dist_d_reg <= 25'(ra_d_reg);
        dp         = 26'(ra_d_reg) - 26'(dist_d_reg);
        dep_e_next = sat_coord(SAT_IN_BITS'(dp));
        for (int i = 0; i < 3; i++) begin
            prod_e_next[i] = 45'(coord_of(bs_d_reg, i)) * 45'(dist_d_reg);
        end
    end

    // stage F: plane contact point and sideband assembly
    always_comb begin
        logic signed [44:0] pr;
        logic signed [27:0] pc;
        coord_t             p [3];
        for (int i = 0; i < 3; i++) begin
            pr   = prod_e_reg[i] + RND_PROD;
            pc   = 28'(coord_of(ap_e_reg, i)) - 28'($signed(pr[44:NORM_FRAC]));
            p[i] = sat_coord(SAT_IN_BITS'(pc));
        end
        side_f_next.func = func_e_reg;
        case (func_e_reg)
            FUNC_SPH_PLANE: side_f_next.early_hit = pl_e_reg;
            FUNC_BOX_BOX:   side_f_next.early_hit = box_e_reg;
            FUNC_SPH_BOX:   side_f_next.early_hit = sb_e_reg;
            default:        side_f_next.early_hit = 1'b0;
        endcase
        side_f_next.pos  = (func_e_reg == FUNC_SPH_PLANE) ? pack3(p[0], p[1], p[2]) : '0;
        side_f_next.norm = (func_e_reg == FUNC_SPH_PLANE) ? bs_e_reg : '0;
        side_f_next.dep  = (func_e_reg == FUNC_SPH_PLANE) ? dep_e_reg : '0;
        side_f_next.ap   = ap_e_reg;
        side_f_next.ra   = ra_e_reg;
        side_f_next.rsum = rsum_e_reg;
        dir_f_next.sgn   = sgn_e_reg;
        dir_f_next.zero  = (s_e_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            func_a_reg <= func_t'(func);
            ap_a_reg   <= a_pos;
            as_a_reg   <= a_size;
            bp_a_reg   <= b_pos;
            bs_a_reg   <= b_size;

            func_b_reg <= func_a_reg;
            ap_b_reg   <= ap_a_reg;
            bs_b_reg   <= bs_a_reg;
            ra_b_reg   <= coord_of(as_a_reg, 0);
            rb_b_reg   <= coord_of(bs_a_reg, 0);
            box_b_reg  <= box_b_next;
            d_b_reg    <= d_b_next;
            e_b_reg    <= e_b_next;

            func_c_reg <= func_b_reg;
            ap_c_reg   <= ap_b_reg;
            bs_c_reg   <= bs_b_reg;
            ra_c_reg   <= ra_b_reg;
            rsum_c_reg <= DIFF_BITS'(ra_b_reg) + DIFF_BITS'(rb_b_reg);
            box_c_reg  <= box_b_reg;
            d_c_reg    <= d_b_reg;
            dsq_c_reg  <= dsq_c_next;
            esq_c_reg  <= esq_c_next;
            pp_c_reg   <= pp_c_next;
            rr_c_reg   <= rr_c_next;

            func_d_reg <= func_c_reg;
            ap_d_reg   <= ap_c_reg;
            bs_d_reg   <= bs_c_reg;
            ra_d_reg   <= ra_c_reg;
            rsum_d_reg <= rsum_c_reg;
            box_d_reg  <= box_c_reg;
            sb_d_reg   <= sb_d_next;
            s_d_reg    <= s_d_next;
            dist_d_reg <= dist_d_next;
            mag_d_reg  <= mag_d_next;
            sgn_d_reg  <= sgn_d_next;

            func_e_reg <= func_d_reg;
            ap_e_reg   <= ap_d_reg;
            bs_e_reg   <= bs_d_reg;
            ra_e_reg   <= ra_d_reg;
            rsum_e_reg <= rsum_d_reg;
            box_e_reg  <= box_d_reg;
            sb_e_reg   <= sb_d_reg;
            pl_e_reg   <= pl_e_next;
            dep_e_reg  <= dep_e_next;
            prod_e_reg <= prod_e_next;
            s_e_reg    <= s_d_reg;
            mag_e_reg  <= mag_d_reg;
            sgn_e_reg  <= sgn_d_reg;

            side_f_reg <= side_f_next;
            s_f_reg    <= s_e_reg;
            mag_f_reg  <= mag_e_reg;
            dir_f_reg  <= dir_f_next;
        end
    end

    assign out_valid = vf_reg;
    assign side      = side_f_reg;
    assign sqlen     = s_f_reg;
    assign mag       = mag_f_reg;
    assign dir       = dir_f_reg;

endmodule

// ===== sv/nct_sqrt.sv =====
// ----------------------------------------------------------------------------
// nct_sqrt: pipelined integer square root
// One result bit per stage of floor(sqrt(sqlen * 2^16)).
// ----------------------------------------------------------------------------
module nct_sqrt (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [nct_pkg::SQ_BITS-1:0]      sqlen,
    output logic                             out_valid,
    output logic [nct_pkg::ROOT_BITS-1:0]    root
);
    import nct_pkg::*;

    logic                v_reg [SQRT_STAGES];
    logic [RAD_BITS-1:0] x_reg [SQRT_STAGES], x_next [SQRT_STAGES];
    logic [RAD_BITS:0]   r_reg [SQRT_STAGES], r_next [SQRT_STAGES];

    always_comb begin
        logic [RAD_BITS-1:0] x_in;
        logic [RAD_BITS:0]   r_in, bitv, trial;
        for (int k = 0; k < SQRT_STAGES; k++) begin
            if (k == 0) begin
                x_in = {sqlen, {(2*XP_BITS){1'b0}}};
                r_in = '0;
            end else begin
                x_in = x_reg[k-1];
                r_in = r_reg[k-1];
            end
            bitv  = (RAD_BITS+1)'(1) << (2 * (ROOT_BITS - 1 - k));
            trial = r_in + bitv;
            if ({1'b0, x_in} >= trial) begin
                x_next[k] = x_in - trial[RAD_BITS-1:0];
                r_next[k] = (r_in >> 1) + bitv;
            end else begin
                x_next[k] = x_in;
                r_next[k] = r_in >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < SQRT_STAGES; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int k = 1; k < SQRT_STAGES; k++) begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            r_reg <= r_next;
        end
    end

    assign out_valid = v_reg[SQRT_STAGES-1];
    assign root      = r_reg[SQRT_STAGES-1][ROOT_BITS-1:0];

endmodule

// ===== sv/nct_div.sv =====
// ----------------------------------------------------------------------------
// nct_div: three-lane pipelined restoring divider
// Quotient of round(|d| * 2^26 / root), one bit per later stage per lane.
// ----------------------------------------------------------------------------
module nct_div (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [2:0][nct_pkg::COORD_BITS-1:0]  mag,
    input  logic [nct_pkg::ROOT_BITS-1:0]        den,
    output logic                                 out_valid,
    output logic [2:0][nct_pkg::QUO_BITS-1:0]    quo,
    output logic [nct_pkg::ROOT_BITS-1:0]        den_out
);
    import nct_pkg::*;

    logic                          v_reg   [DIV_STAGES];
    logic [ROOT_BITS-1:0]          den_reg [DIV_STAGES], den_next [DIV_STAGES];
    logic [2:0][DIVND_BITS-1:0]    rem_reg [DIV_STAGES], rem_next [DIV_STAGES];
    logic [2:0][QUO_BITS-1:0]      quo_reg [DIV_STAGES], quo_next [DIV_STAGES];

    always_comb begin
        logic [DIVND_BITS-1:0] shd;
        logic                  ge;
        // first stage: form the rounded dividend
        den_next[0] = den;
        for (int i = 0; i < 3; i++) begin
            rem_next[0][i] = (DIVND_BITS'(mag[i]) << (NORM_FRAC + XP_BITS))
                           + DIVND_BITS'(den >> 1);
            quo_next[0][i] = '0;
        end
        for (int j = 1; j < DIV_STAGES; j++) begin
            den_next[j] = den_reg[j-1];
            for (int i = 0; i < 3; i++) begin
                shd = DIVND_BITS'(den_reg[j-1]) << (QUO_BITS - j);
                ge  = rem_reg[j-1][i] >= shd;
                rem_next[j][i] = ge ? (rem_reg[j-1][i] - shd) : rem_reg[j-1][i];
                quo_next[j][i] = quo_reg[j-1][i] | (QUO_BITS'(ge) << (QUO_BITS - j));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < DIV_STAGES; j++) begin
                v_reg[j] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int j = 1; j < DIV_STAGES; j++) begin
                v_reg[j] <= v_reg[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg <= den_next;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];
    assign quo       = quo_reg[DIV_STAGES-1];
    assign den_out   = den_reg[DIV_STAGES-1];

endmodule

// ===== sv/nct_back.sv =====
// ----------------------------------------------------------------------------
// nct_back: sphere-sphere finish and result register
// Signs the normal, checks the sphere-sphere distance, places the contact
// point and selects the reported fields.
// ----------------------------------------------------------------------------
module nct_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  nct_pkg::side_t                      side,
    input  nct_pkg::dir_t                       dir,
    input  logic [nct_pkg::ROOT_BITS-1:0]       root,
    input  logic [2:0][nct_pkg::QUO_BITS-1:0]   quo,
    output logic                                out_valid,
    output logic                                hit,
    output nct_pkg::vec_t                       contact_pos,
    output nct_pkg::vec_t                       contact_normal,
    output nct_pkg::coord_t                     depth
);
    import nct_pkg::*;

    localparam logic [ROOT_BITS:0] RND_DIST = (ROOT_BITS+1)'(1) << (XP_BITS - 1);
    localparam logic signed [44:0] RND_PROD = 45'sd1 <<< NORM_FRAC;

    // stage G
    logic                vg_reg, hit0_g_reg, hit0_g_next;
    side_t               side_g_reg;
    coord_t              nn_g_reg [3], nn_g_next [3];
    logic signed [23:0]  dep0_g_reg, dep0_g_next;
    logic signed [24:0]  k2_g_reg, k2_g_next;

    // stage H
    logic                vh_reg, hit0_h_reg;
    side_t               side_h_reg;
    coord_t              nn_h_reg [3];
    logic signed [23:0]  dep0_h_reg;
    logic signed [44:0]  prod_h_reg [3], prod_h_next [3];

    // stage I: result register
    logic                out_valid_reg, hit_reg, hit_next;
    vec_t                pos_reg, pos_next, norm_reg, norm_next;
    coord_t              dep_reg, dep_next;

    always_comb begin
        logic [QUO_BITS:0]            qs;
        logic [ROOT_BITS:0]           dsum;
        logic [ROOT_BITS-XP_BITS:0]   cdist;
        for (int i = 0; i < 3; i++) begin
            qs = {1'b0, quo[i]};
            if (dir.zero) begin
                nn_g_next[i] = '0;
            end else if (dir.sgn[i]) begin
                nn_g_next[i] = COORD_BITS'(-$signed(qs));
            end else begin
                nn_g_next[i] = COORD_BITS'($signed(qs));
            end
        end
        dsum        = (ROOT_BITS+1)'(root) + RND_DIST;
        cdist       = dsum[ROOT_BITS:XP_BITS];
        hit0_g_next = $signed({2'b00, cdist}) < 24'(side.rsum);
        dep0_g_next = 24'(side.rsum) - $signed({2'b00, cdist});
        k2_g_next   = (25'(side.ra) <<< 1) - 25'(dep0_g_next);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod_h_next[i] = 45'(nn_g_reg[i]) * 45'(k2_g_reg);
        end
    end

    always_comb begin
        logic signed [44:0] pr;
        logic signed [26:0] pc;
        coord_t             p [3];
        for (int i = 0; i < 3; i++) begin
            pr   = prod_h_reg[i] + RND_PROD;
            pc   = 27'(coord_of(side_h_reg.ap, i)) - 27'($signed(pr[44:NORM_FRAC+1]));
            p[i] = sat_coord(SAT_IN_BITS'(pc));
        end
        hit_next  = (side_h_reg.func == FUNC_SPH_SPH) ? hit0_h_reg : side_h_reg.early_hit;
        pos_next  = '0;
        norm_next = '0;
        dep_next  = '0;
        if (hit_next) begin
            case (side_h_reg.func)
                FUNC_SPH_SPH: begin
                    pos_next  = pack3(p[0], p[1], p[2]);
                    norm_next = pack3(nn_h_reg[0], nn_h_reg[1], nn_h_reg[2]);
                    dep_next  = sat_coord(SAT_IN_BITS'(dep0_h_reg));
                end
                FUNC_SPH_PLANE: begin
                    pos_next  = side_h_reg.pos;
                    norm_next = side_h_reg.norm;
                    dep_next  = side_h_reg.dep;
                end
                FUNC_SPH_BOX: begin
                    norm_next = pack3(nn_h_reg[0], nn_h_reg[1], nn_h_reg[2]);
                end
                default: begin
                    pos_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vg_reg        <= 1'b0;
            vh_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            vg_reg        <= in_valid;
            vh_reg        <= vg_reg;
            out_valid_reg <= vh_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_g_reg <= side;
            nn_g_reg   <= nn_g_next;
            hit0_g_reg <= hit0_g_next;
            dep0_g_reg <= dep0_g_next;
            k2_g_reg   <= k2_g_next;

            side_h_reg <= side_g_reg;
            nn_h_reg   <= nn_g_reg;
            hit0_h_reg <= hit0_g_reg;
            dep0_h_reg <= dep0_g_reg;
            prod_h_reg <= prod_h_next;

            hit_reg  <= hit_next;
            pos_reg  <= pos_next;
            norm_reg <= norm_next;
            dep_reg  <= dep_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign hit            = hit_reg;
    assign contact_pos    = pos_reg;
    assign contact_normal = norm_reg;
    assign depth          = dep_reg;

endmodule

// ===== sv/narrowphase_collision_test_top.sv =====
// ----------------------------------------------------------------------------
// narrowphase_collision_test_top: narrow-phase pair test pipeline
// Sphere-sphere, sphere-plane, box-box and sphere-box overlap; contact point,
// unit normal and depth for sphere-sphere and sphere-plane, a normal for sphere-box.
// ----------------------------------------------------------------------------
//  channel | ports             | carries
//  --------+-------------------+-----------------------------------------
//  input   | s_valid / s_ready | s_func, s_a_pos, s_a_size, s_b_pos, s_b_size
//  result  | m_valid / m_ready | m_hit, m_contact_pos, m_contact_normal, m_depth
//
//  One item enters per cycle unless a result waits with m_ready low.
//  The pipeline is built around the 29-stage square root and the 20-stage divider.
//  Reset (aresetn low at a clock edge) empties the pipeline; no clearing pass.
//  While a result waits with m_ready low, the whole pipeline holds in place.
// ----------------------------------------------------------------------------
module narrowphase_collision_test_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_func,
    input  logic [nct_pkg::VEC_BITS-1:0]        s_a_pos,
    input  logic [nct_pkg::VEC_BITS-1:0]        s_a_size,
    input  logic [nct_pkg::VEC_BITS-1:0]        s_b_pos,
    input  logic [nct_pkg::VEC_BITS-1:0]        s_b_size,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_hit,
    output logic [nct_pkg::VEC_BITS-1:0]        m_contact_pos,
    output logic [nct_pkg::VEC_BITS-1:0]        m_contact_normal,
    output logic signed [nct_pkg::COORD_BITS-1:0] m_depth
);
    import nct_pkg::*;

    typedef struct packed {
        side_t                      side;
        logic [2:0][COORD_BITS-1:0] mag;
        dir_t                       dir;
    } mid_t;

    typedef struct packed {
        side_t side;
        dir_t  dir;
    } tail_t;

    logic                        en;
    logic                        fr_valid, sq_valid, dv_valid;
    side_t                       fr_side;
    logic [SQ_BITS-1:0]          fr_sqlen;
    logic [2:0][COORD_BITS-1:0]  fr_mag;
    dir_t                        fr_dir;
    logic [ROOT_BITS-1:0]        sq_root, dv_den;
    logic [2:0][QUO_BITS-1:0]    dv_quo;
    mid_t                        mid_next;
    mid_t                        mid_reg  [SQRT_STAGES];
    tail_t                       tail_next;
    tail_t                       tail_reg [DIV_STAGES];

    // advance everything together unless a finished result is held
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    nct_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .func      (s_func),
        .a_pos     (s_a_pos),
        .a_size    (s_a_size),
        .b_pos     (s_b_pos),
        .b_size    (s_b_size),
        .out_valid (fr_valid),
        .side      (fr_side),
        .sqlen     (fr_sqlen),
        .mag       (fr_mag),
        .dir       (fr_dir)
    );

    nct_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .sqlen     (fr_sqlen),
        .out_valid (sq_valid),
        .root      (sq_root)
    );

    // sideband follows the square root
    assign mid_next.side = fr_side;
    assign mid_next.mag  = fr_mag;
    assign mid_next.dir  = fr_dir;

    always_ff @(posedge aclk) begin
        if (en) begin
            mid_reg[0] <= mid_next;
            for (int k = 1; k < SQRT_STAGES; k++) begin
                mid_reg[k] <= mid_reg[k-1];
            end
        end
    end

    nct_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .mag       (mid_reg[SQRT_STAGES-1].mag),
        .den       (sq_root),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .den_out   (dv_den)
    );

    // sideband follows the divider
    assign tail_next.side = mid_reg[SQRT_STAGES-1].side;
    assign tail_next.dir  = mid_reg[SQRT_STAGES-1].dir;

    always_ff @(posedge aclk) begin
        if (en) begin
            tail_reg[0] <= tail_next;
            for (int k = 1; k < DIV_STAGES; k++) begin
                tail_reg[k] <= tail_reg[k-1];
            end
        end
    end

    nct_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .in_valid       (dv_valid),
        .side           (tail_reg[DIV_STAGES-1].side),
        .dir            (tail_reg[DIV_STAGES-1].dir),
        .root           (dv_den),
        .quo            (dv_quo),
        .out_valid      (m_valid),
        .hit            (m_hit),
        .contact_pos    (m_contact_pos),
        .contact_normal (m_contact_normal),
        .depth          (m_depth)
    );

endmodule

// ===== sv/nct_checker.sv =====
// ----------------------------------------------------------------------------
// nct_checker: port-level checks for the narrow-phase pair test
// Watches the top-level handshakes and result fields; bound to the top level.
// ----------------------------------------------------------------------------
module nct_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [1:0]                          s_func,
    input  logic [nct_pkg::VEC_BITS-1:0]        s_a_pos,
    input  logic [nct_pkg::VEC_BITS-1:0]        s_a_size,
    input  logic [nct_pkg::VEC_BITS-1:0]        s_b_pos,
    input  logic [nct_pkg::VEC_BITS-1:0]        s_b_size,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic                                m_hit,
    input  logic [nct_pkg::VEC_BITS-1:0]        m_contact_pos,
    input  logic [nct_pkg::VEC_BITS-1:0]        m_contact_normal,
    input  logic signed [nct_pkg::COORD_BITS-1:0] m_depth
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_contact_pos)
            && $stable(m_contact_normal) && $stable(m_depth))
        else $error("held result changed");

    // input side stalls only while a result is held
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow result stall");

    // a miss reports nothing else
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_contact_pos == '0 && m_contact_normal == '0
            && m_depth == '0)
        else $error("miss with nonzero contact fields");

endmodule

bind narrowphase_collision_test_top nct_checker u_nct_checker (.*);
